// File: sv/cmapgl_pkg.sv
// cmapgl_pkg: shared constants, codes and types for the segmented
// character map lookup block; used by cmap_segment_glyph_lookup
// no dependencies
package cmapgl_pkg;

  // memory geometry
  localparam int MEM_WORDS  = 4096;
  localparam int MEM_AW     = $clog2(MEM_WORDS);
  // computed word addresses reach about 8 + 4 * 1023 + 32767 + 65535
  localparam int ADDR_W     = 17;
  localparam int WORD_W     = 16;

  // field widths
  localparam int SEG_W      = 10;
  localparam int FMT_W      = 4;
  localparam int CODE_W     = 21;
  localparam int WADDR_W    = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  // subtable layout: end codes at 7, other arrays follow from 8
  localparam logic [ADDR_W-1:0] END_BASE   = ADDR_W'(7);
  localparam logic [ADDR_W-1:0] ARRAY_BASE = ADDR_W'(8);
  localparam logic [FMT_W-1:0]  FMT_SEGMENTED = FMT_W'(4);

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEG_COUNT    = 1'b0,
    CFG_TABLE_FORMAT = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_END,
    S_RD_START,
    S_CMP,
    S_RD_RO,
    S_RD_GLYPH,
    S_GLYPH,
    S_DONE
  } state_t;

  // midpoint of the open search window [lo, hx)
  function automatic logic [SEG_W-1:0] mid_of(input logic [SEG_W:0] lo,
                                              input logic [SEG_W:0] hx);
    logic [SEG_W+1:0] sum;
    sum = {1'b0, lo} + {1'b0, hx} - (SEG_W+2)'(1);
    return sum[SEG_W:1];
  endfunction

endpackage

// File: sv/cmapgl_ram.sv
// cmapgl_ram: generic simple dual-port RAM, one write and one read port,
// read data registered
// no dependencies
module cmapgl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/cmap_segment_glyph_lookup.sv
// cmap_segment_glyph_lookup: top level, segmented character map lookup
// depends on cmapgl_pkg and cmapgl_ram
//
// Usage
//   in_*  : valid/ready channel. in_cmd = load stores in_word_data at
//           in_word_addr in the subtable memory; in_cmd = lookup maps
//           in_code_point to a glyph index. Loads give no result.
//   out_* : valid/ready channel, one out_glyph_id per lookup.
//   cfg_* : write channel, always ready; index 0 = segment count,
//           index 1 = table format. Write only while the block is idle.
// Timing
//   a load is written at its transfer edge and in_ready stays high, so
//   loads can follow back to back.
//   a lookup binary-searches the segments through the single memory read
//   port: the first end code read, a start code read and a compare per
//   probe (10 probes for 1023 segments), up to three reads for delta, range
//   offset and glyph array, then the output register. in_ready rises with
//   out_valid, so the next lookup is taken only once the last result is in
//   the output register. An unsupported format or a code above 0xFFFF
//   skips the search and goes straight to the output register.
// Reset: segment count 1, format 4, output empty; memory content is
//   undefined until loaded (no clearing pass).
// Stall: a finished result waits in the output register; the block takes a
//   new item, then holds its result, in_ready low, until that one transfers.
module cmap_segment_glyph_lookup
  import cmapgl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_cmd,
  input  logic [WADDR_W-1:0]    in_word_addr,
  input  logic [WORD_W-1:0]     in_word_data,
  input  logic [CODE_W-1:0]     in_code_point,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [WORD_W-1:0]     out_glyph_id,
  // configuration channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  state_t              state_r, state_nxt;
  logic [SEG_W:0]      lo_r, lo_nxt;
  logic [SEG_W:0]      hx_r, hx_nxt;
  logic [SEG_W-1:0]    mid_r, mid_nxt;
  logic [SEG_W-1:0]    seg_r, seg_nxt;
  logic [WORD_W-1:0]   code_r, code_nxt;
  logic [WORD_W-1:0]   end_r, end_nxt;
  logic [WORD_W-1:0]   start_r, start_nxt;
  logic [WORD_W-1:0]   delta_r, delta_nxt;
  logic [ADDR_W-1:0]   ro_addr_r, ro_addr_nxt;
  logic [WORD_W-1:0]   result_r, result_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]   out_glyph_r, out_glyph_nxt;
  logic [SEG_W-1:0]    seg_count_r;
  logic [FMT_W-1:0]    fmt_r;
  logic                oor_r;

  logic                in_fire;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic [WORD_W-1:0]   ram_q;
  logic [WORD_W-1:0]   rd_word;
  logic                ld_en;
  logic [ADDR_W-1:0]   ld_addr;
  logic [ADDR_W-1:0]   seg_x;
  logic [ADDR_W-1:0]   mid_x;
  logic [SEG_W-1:0]    mid_cur;
  logic [SEG_W:0]      srch_lo;
  logic [SEG_W:0]      srch_hx;
  logic [SEG_W-1:0]    srch_mid;

  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid    = out_valid_r;
  assign out_glyph_id = out_glyph_r;

  // load path: addresses past the memory are dropped
  assign ld_addr = ADDR_W'(in_word_addr);
  assign ld_en   = in_fire && (in_cmd == CMD_LOAD) && (ld_addr < ADDR_W'(MEM_WORDS));

  // subtable memory
  cmapgl_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MEM_WORDS)
  ) u_words (
    .clk   (clk),
    .we    (ld_en),
    .waddr (ld_addr[MEM_AW-1:0]),
    .wdata (in_word_data),
    .re    (rd_en),
    .raddr (rd_addr[MEM_AW-1:0]),
    .rdata (ram_q)
  );

  // reads past the memory return zero
  always_ff @(posedge clk) begin
    if (rd_en) begin
      oor_r <= (rd_addr >= ADDR_W'(MEM_WORDS));
    end
  end
  assign rd_word = oor_r ? '0 : ram_q;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_count_r <= SEG_W'(1);
      fmt_r       <= FMT_SEGMENTED;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SEG_COUNT:    seg_count_r <= cfg_data[SEG_W-1:0];
        CFG_TABLE_FORMAT: fmt_r       <= cfg_data[FMT_W-1:0];
        default:          ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // search and payload registers
  always_ff @(posedge clk) begin
    lo_r        <= lo_nxt;
    hx_r        <= hx_nxt;
    mid_r       <= mid_nxt;
    seg_r       <= seg_nxt;
    code_r      <= code_nxt;
    end_r       <= end_nxt;
    start_r     <= start_nxt;
    delta_r     <= delta_nxt;
    ro_addr_r   <= ro_addr_nxt;
    result_r    <= result_nxt;
    out_glyph_r <= out_glyph_nxt;
  end

  assign seg_x   = ADDR_W'(seg_r);
  assign mid_x   = ADDR_W'(mid_r);
  assign mid_cur = mid_of(lo_r, hx_r);

  // narrowed window after a miss compare
  always_comb begin
    srch_lo = lo_r;
    srch_hx = hx_r;
    if (code_r < rd_word) begin
      srch_hx = {1'b0, mid_r};
    end else begin
      srch_lo = {1'b0, mid_r} + (SEG_W+1)'(1);
    end
    srch_mid = mid_of(srch_lo, srch_hx);
  end

  // lookup sequencer
  always_comb begin
    state_nxt     = state_r;
    lo_nxt        = lo_r;
    hx_nxt        = hx_r;
    mid_nxt       = mid_r;
    seg_nxt       = seg_r;
    code_nxt      = code_r;
    end_nxt       = end_r;
    start_nxt     = start_r;
    delta_nxt     = delta_r;
    ro_addr_nxt   = ro_addr_r;
    result_nxt    = result_r;
    out_glyph_nxt = out_glyph_r;
    out_valid_nxt = out_valid_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    in_ready      = (state_r == S_IDLE);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire && (in_cmd == CMD_LOOKUP)) begin
          code_nxt = in_code_point[WORD_W-1:0];
          seg_nxt  = seg_count_r;
          lo_nxt   = '0;
          hx_nxt   = {1'b0, seg_count_r};
          if ((in_code_point[CODE_W-1:WORD_W] != '0) || (fmt_r != FMT_SEGMENTED)) begin
            result_nxt = '0;
            state_nxt  = S_DONE;
          end else begin
            state_nxt  = S_RD_END;
          end
        end
      end
      S_RD_END: begin
        if (lo_r >= hx_r) begin
          result_nxt = '0;
          state_nxt  = S_DONE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = END_BASE + ADDR_W'(mid_cur);
          mid_nxt   = mid_cur;
          state_nxt = S_RD_START;
        end
      end
      S_RD_START: begin
        end_nxt   = rd_word;
        rd_en     = 1'b1;
        rd_addr   = ARRAY_BASE + seg_x + mid_x;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if ((code_r >= rd_word) && (code_r <= end_r)) begin
          // segment hit: fetch its delta
          start_nxt = rd_word;
          rd_en     = 1'b1;
          rd_addr   = ARRAY_BASE + (seg_x << 1) + mid_x;
          state_nxt = S_RD_RO;
        end else if (srch_lo < srch_hx) begin
          // next probe: issue its end code read right away
          lo_nxt    = srch_lo;
          hx_nxt    = srch_hx;
          mid_nxt   = srch_mid;
          rd_en     = 1'b1;
          rd_addr   = END_BASE + ADDR_W'(srch_mid);
          state_nxt = S_RD_START;
        end else begin
          lo_nxt     = srch_lo;
          hx_nxt     = srch_hx;
          result_nxt = '0;
          state_nxt  = S_DONE;
        end
      end
      S_RD_RO: begin
        delta_nxt   = rd_word;
        ro_addr_nxt = ARRAY_BASE + (seg_x << 1) + seg_x + mid_x;
        rd_en       = 1'b1;
        rd_addr     = ARRAY_BASE + (seg_x << 1) + seg_x + mid_x;
        state_nxt   = S_RD_GLYPH;
      end
      S_RD_GLYPH: begin
        if (rd_word == '0) begin
          result_nxt = delta_r + code_r;
          state_nxt  = S_DONE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = ro_addr_r + ADDR_W'(rd_word >> 1) + ADDR_W'(code_r - start_r);
          state_nxt = S_GLYPH;
        end
      end
      S_GLYPH: begin
        result_nxt = (rd_word == '0) ? '0 : (rd_word + delta_r);
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_glyph_nxt = result_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // unsupported format goes straight to a zero result (checked for format only)
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_cmd == CMD_LOOKUP) && (fmt_r != FMT_SEGMENTED))
    |=> (state_r == S_DONE) && (result_r == '0))
    else $error("rejected lookup did not give zero");

  // a load never starts the sequencer
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_cmd == CMD_LOAD)) |=> (state_r == S_IDLE))
    else $error("load left idle");

  // search window stays ordered and inside the segment range
  a_window: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_RD_START) || (state_r == S_CMP))
    |-> (lo_r < hx_r) && (hx_r <= {1'b0, seg_r}) && ({1'b0, mid_r} < hx_r))
    else $error("search window out of order");

  // a new result only comes out of the done state
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result without finished lookup");

  // memory reads never happen while idle or delivering
  a_read_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_IDLE) || (state_r == S_DONE)) |-> !rd_en)
    else $error("stray memory read");
`endif

endmodule
